FILE: sv/lsmr_pkg.sv
`timescale 1ns / 1ps

package lsmr_pkg;

   // Word and field widths
   localparam int DATA_W   = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // Default number of stored words
   localparam int DEPTH_DEFAULT = 16;

   // Opcodes
   localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
   localparam logic [OP_W-1:0] OP_POP  = 2'd1;
   localparam logic [OP_W-1:0] OP_PEEK = 2'd2;
   localparam logic [OP_W-1:0] OP_REV  = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;

endpackage

FILE: sv/lifo_stack_with_middle_reverse_core.sv
`timescale 1ns / 1ps

// LIFO stack of DEPTH signed 32-bit words held in one synchronous memory with
// one write port and two registered read ports. A word is accepted when start
// is high and busy is low; every word gives exactly one result, shown for one
// cycle with rsp_strobe, and the receiver cannot stall it. Push, and any pop,
// peek or reverse that has nothing to read or swap, answers on the cycle after
// acceptance with busy staying low, so one such word per cycle. A pop or peek
// of a stored word first reads the memory into its read register, then loads
// the result register in S_READ; busy is high for one cycle, so no new word is
// taken until the read is done. Reverse-middle swaps entries t..count-t-1 with
// t = (count+2)/4; each swap reads both ends, then writes low, then writes
// high, floor((count-2t)/2) swaps in all, with busy high all the while.
// The memory needs no clearing after reset; only entries below the count are
// ever used.
module lifo_stack_with_middle_reverse_core #(
   parameter int DEPTH = lsmr_pkg::DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [lsmr_pkg::OP_W-1:0]             req_opcode,
   input  logic signed [lsmr_pkg::DATA_W-1:0]    req_value,
   output logic                                  rsp_strobe,
   output logic signed [lsmr_pkg::DATA_W-1:0]    rsp_data,
   output logic [lsmr_pkg::STATUS_W-1:0]         rsp_status,
   output logic [lsmr_pkg::COUNT_W-1:0]          rsp_count,
   output logic                                  rsp_is_empty
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SWAP_RD,
      S_WR_LO,
      S_WR_HI
   } state_type;

   state_type                          state_ff, state_in;
   logic [FILL_W-1:0]                  fill_ff, fill_in;
   logic [FILL_W-1:0]                  lo_ff, lo_in;
   logic [FILL_W-1:0]                  hi_ff, hi_in;
   logic                               strobe_ff, strobe_in;
   logic [lsmr_pkg::DATA_W-1:0]        data_ff, data_in;
   logic [lsmr_pkg::STATUS_W-1:0]      status_ff, status_in;
   logic [lsmr_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic                               empty_ff, empty_in;

   // Memory and its ports
   logic [lsmr_pkg::DATA_W-1:0]        mem [DEPTH];
   logic [lsmr_pkg::DATA_W-1:0]        rd_a_ff, rd_b_ff;
   logic                               mem_we, mem_re;
   logic [ADDR_W-1:0]                  mem_waddr, mem_raddr_a, mem_raddr_b;
   logic [lsmr_pkg::DATA_W-1:0]        mem_wdata;

   // Derived pointers
   logic [FILL_W-1:0]                  fill_m1, hi_m1, t_val;
   logic [FILL_W:0]                    fill_p2;
   logic [FILL_W+lsmr_pkg::COUNT_W-1:0] count_ext;
   logic                               accept;

   assign accept  = start && !busy;
   assign fill_m1 = fill_ff - FILL_W'(1);
   assign hi_m1   = hi_ff - FILL_W'(1);
   assign fill_p2 = {1'b0, fill_ff} + (FILL_W+1)'(2);
   assign t_val   = {1'b0, fill_p2[FILL_W:2]};

   // Next state, memory controls and result
   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      strobe_in   = 1'b0;
      data_in     = data_ff;
      status_in   = status_ff;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_waddr   = fill_ff[ADDR_W-1:0];
      mem_wdata   = req_value;
      mem_raddr_a = fill_m1[ADDR_W-1:0];
      mem_raddr_b = hi_m1[ADDR_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               data_in   = '0;
               status_in = lsmr_pkg::ST_OK;
               unique case (req_opcode)
                  lsmr_pkg::OP_PUSH: begin
                     strobe_in = 1'b1;
                     if (fill_ff == FILL_W'(DEPTH)) begin
                        status_in = lsmr_pkg::ST_OVER;
                     end else begin
                        mem_we  = 1'b1;
                        fill_in = fill_ff + FILL_W'(1);
                     end
                  end
                  lsmr_pkg::OP_POP, lsmr_pkg::OP_PEEK: begin
                     if (fill_ff == '0) begin
                        strobe_in = 1'b1;
                        status_in = lsmr_pkg::ST_UNDER;
                     end else begin
                        mem_re   = 1'b1;
                        state_in = S_READ;
                        if (req_opcode == lsmr_pkg::OP_POP) begin
                           fill_in = fill_m1;
                        end
                     end
                  end
                  lsmr_pkg::OP_REV: begin
                     lo_in = t_val;
                     hi_in = fill_ff - t_val;
                     if (({1'b0, t_val} + (FILL_W+1)'(1)) < {1'b0, fill_ff - t_val}) begin
                        state_in = S_SWAP_RD;
                     end else begin
                        strobe_in = 1'b1;
                     end
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            strobe_in = 1'b1;
            data_in   = rd_a_ff;
            state_in  = S_IDLE;
         end
         S_SWAP_RD: begin
            mem_re      = 1'b1;
            mem_raddr_a = lo_ff[ADDR_W-1:0];
            state_in    = S_WR_LO;
         end
         S_WR_LO: begin
            mem_we    = 1'b1;
            mem_waddr = lo_ff[ADDR_W-1:0];
            mem_wdata = rd_b_ff;
            state_in  = S_WR_HI;
         end
         S_WR_HI: begin
            mem_we    = 1'b1;
            mem_waddr = hi_m1[ADDR_W-1:0];
            mem_wdata = rd_a_ff;
            lo_in     = lo_ff + FILL_W'(1);
            hi_in     = hi_m1;
            if (({1'b0, lo_ff} + (FILL_W+1)'(3)) < {1'b0, hi_ff}) begin
               state_in = S_SWAP_RD;
            end else begin
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      count_ext = {{lsmr_pkg::COUNT_W{1'b0}}, fill_in};
      count_in  = count_ext[lsmr_pkg::COUNT_W-1:0];
      empty_in  = (fill_in == '0);
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         fill_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         strobe_ff <= strobe_in;
      end
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      data_ff   <= data_in;
      status_ff <= status_in;
      count_ff  <= count_in;
      empty_ff  <= empty_in;
   end

   // Write one word, read two words with registered data
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_a_ff <= mem[mem_raddr_a];
         rd_b_ff <= mem[mem_raddr_b];
      end
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_strobe   = strobe_ff;
   assign rsp_data     = data_ff;
   assign rsp_status   = status_ff;
   assign rsp_count    = count_ff;
   assign rsp_is_empty = empty_ff;

   // Checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(DEPTH))
      else $error("fill exceeds depth");

   a_push_answers: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == lsmr_pkg::OP_PUSH) |=> rsp_strobe)
      else $error("push gave no result on the next cycle");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != lsmr_pkg::ST_OK) |-> rsp_data == '0)
      else $error("error result carries a nonzero word");

   a_swap_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWAP_RD) |-> (({1'b0, lo_ff} + (FILL_W+1)'(1)) < {1'b0, hi_ff}))
      else $error("swap issued with crossed pointers");

   a_pop_waits: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == lsmr_pkg::OP_POP && fill_ff != '0)
      |=> (busy && !rsp_strobe) ##1 rsp_strobe)
      else $error("pop of a stored word not answered after its read");

endmodule

FILE: tb/sv/lifo_stack_with_middle_reverse_core_test.sv
`timescale 1ns / 1ps

module lifo_stack_with_middle_reverse_core_test;

   localparam int STACK_DEPTH = lsmr_pkg::DEPTH_DEFAULT;
   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic signed [lsmr_pkg::DATA_W-1:0] data;
      logic [lsmr_pkg::STATUS_W-1:0]      status;
      logic [lsmr_pkg::COUNT_W-1:0]       count;
      logic                               is_empty;
   } stack_reply_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               start = 1'b0;
   logic                               busy;
   logic [lsmr_pkg::OP_W-1:0]          req_opcode = lsmr_pkg::OP_PUSH;
   logic signed [lsmr_pkg::DATA_W-1:0] req_value = '0;
   logic                               rsp_strobe;
   logic signed [lsmr_pkg::DATA_W-1:0] rsp_data;
   logic [lsmr_pkg::STATUS_W-1:0]      rsp_status;
   logic [lsmr_pkg::COUNT_W-1:0]       rsp_count;
   logic                               rsp_is_empty;

   // Shadow copy of the stack and the replies still owed by the block
   logic signed [lsmr_pkg::DATA_W-1:0] shadow_words [STACK_DEPTH];
   int                                 shadow_fill = 0;
   stack_reply_type                    pending_replies [$];
   int                                 mismatch_count = 0;
   int                                 quiet_cycles = 0;

   lifo_stack_with_middle_reverse_core #(
      .DEPTH(STACK_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_value(req_value),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .rsp_status(rsp_status),
      .rsp_count(rsp_count),
      .rsp_is_empty(rsp_is_empty)
   );

   always #2 clock = ~clock;

   // Apply one word to the shadow stack and return the reply it owes
   function automatic stack_reply_type apply_stack_op(
         logic [lsmr_pkg::OP_W-1:0] op,
         logic signed [lsmr_pkg::DATA_W-1:0] value);
      stack_reply_type                    reply;
      int                                 lo;
      int                                 hi;
      logic signed [lsmr_pkg::DATA_W-1:0] held;
      reply.data   = '0;
      reply.status = lsmr_pkg::ST_OK;
      case (op)
         lsmr_pkg::OP_PUSH: begin
            if (shadow_fill >= STACK_DEPTH) begin
               reply.status = lsmr_pkg::ST_OVER;
            end else begin
               shadow_words[shadow_fill] = value;
               shadow_fill++;
            end
         end
         lsmr_pkg::OP_POP: begin
            if (shadow_fill == 0) begin
               reply.status = lsmr_pkg::ST_UNDER;
            end else begin
               shadow_fill--;
               reply.data = shadow_words[shadow_fill];
            end
         end
         lsmr_pkg::OP_PEEK: begin
            if (shadow_fill == 0) reply.status = lsmr_pkg::ST_UNDER;
            else reply.data = shadow_words[shadow_fill - 1];
         end
         default: begin
            // flip the middle half, skipping round(count/4) words at each end
            lo = (shadow_fill + 2) / 4;
            hi = shadow_fill - lo;
            while (lo + 1 < hi) begin
               held                 = shadow_words[hi - 1];
               shadow_words[hi - 1] = shadow_words[lo];
               shadow_words[lo]     = held;
               lo++;
               hi--;
            end
         end
      endcase
      reply.count    = shadow_fill[lsmr_pkg::COUNT_W-1:0];
      reply.is_empty = (shadow_fill == 0);
      return reply;
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Favor the sign and range extremes now and then
   function automatic logic signed [lsmr_pkg::DATA_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return {1'b1, {(lsmr_pkg::DATA_W-1){1'b0}}};
         1: return {1'b0, {(lsmr_pkg::DATA_W-1){1'b1}}};
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Drive one word after an idle gap and hold it until the block takes it
   task automatic send_word(input logic [lsmr_pkg::OP_W-1:0] op,
                            input logic signed [lsmr_pkg::DATA_W-1:0] value,
                            input int gap);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start      <= 1'b1;
      req_opcode <= op;
      req_value  <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_replies.push_back(apply_stack_op(op, value));
   endtask

   // Hold off the sender until every owed reply has come back
   task automatic drain_replies();
      @(negedge clock);
      start <= 1'b0;
      while (pending_replies.size() > 0) @(posedge clock);
   endtask

   task automatic test_empty_stack();
      send_word(lsmr_pkg::OP_POP, 32'sd7, 0);
      send_word(lsmr_pkg::OP_PEEK, 32'sd7, 1);
      send_word(lsmr_pkg::OP_REV, 32'sd7, 0);
      drain_replies();
   endtask

   task automatic test_full_stack();
      logic signed [lsmr_pkg::DATA_W-1:0] seeds [6];
      seeds[0] = {1'b1, {(lsmr_pkg::DATA_W-1){1'b0}}};
      seeds[1] = {1'b0, {(lsmr_pkg::DATA_W-1){1'b1}}};
      seeds[2] = '0;
      seeds[3] = '1;
      seeds[4] = 32'sh5555_5555;
      seeds[5] = 32'shAAAA_AAAA;
      for (int i = 0; i < STACK_DEPTH; i++)
         send_word(lsmr_pkg::OP_PUSH, (i < 6) ? seeds[i] : $urandom, pick_gap());
      // push on a full stack drops the word
      send_word(lsmr_pkg::OP_PUSH, 32'sd12345, 0);
      send_word(lsmr_pkg::OP_REV, '0, 0);
      send_word(lsmr_pkg::OP_PEEK, '0, 0);
      send_word(lsmr_pkg::OP_POP, '0, 2);
      drain_replies();
   endtask

   // Random words; push_weight steers the fill level up or down
   task automatic test_random_mix(input int words, input int push_weight,
                                  input int rev_weight, input bit back_to_back);
      int                        r;
      logic [lsmr_pkg::OP_W-1:0] op;
      for (int i = 0; i < words; i++) begin
         r = $urandom_range(0, 99);
         if (r < push_weight) op = lsmr_pkg::OP_PUSH;
         else if (r < push_weight + rev_weight) op = lsmr_pkg::OP_REV;
         else op = $urandom_range(0, 1) ? lsmr_pkg::OP_POP : lsmr_pkg::OP_PEEK;
         send_word(op, pick_value(), back_to_back ? 0 : pick_gap());
      end
      drain_replies();
   endtask

   // Compare each reply with the oldest owed one
   always @(posedge clock) begin
      stack_reply_type want;
      if (!reset && rsp_strobe) begin
         if (pending_replies.size() == 0) begin
            $error("rsp_strobe: reply with no word outstanding");
            mismatch_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_data !== want.data) begin
               $error("rsp_data: expected %0d, got %0d", want.data, rsp_data);
               mismatch_count++;
            end
            if (rsp_status !== want.status) begin
               $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_count !== want.count) begin
               $error("rsp_count: expected %0d, got %0d", want.count, rsp_count);
               mismatch_count++;
            end
            if (rsp_is_empty !== want.is_empty) begin
               $error("rsp_is_empty: expected %0d, got %0d", want.is_empty, rsp_is_empty);
               mismatch_count++;
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_stack();
      test_full_stack();
      test_random_mix(450, 50, 10, 1'b0);
      test_random_mix(450, 70, 10, 1'b1);
      test_random_mix(450, 30, 10, 1'b0);
      test_random_mix(450, 45, 25, 1'b0);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_replies.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
